// File: src/assert_macros.svh
// Assertion helper macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: src/dfmod_pkg.sv
// ----------------------------------------------------------------------------
// dfmod_pkg: shared types for the binary64 remainder block
// Payload structs, controller states and the command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package dfmod_pkg;
	localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
	localparam logic [62:0] INF_MAG   = {11'h7FF, 52'd0};
	localparam logic [52:0] HIDDEN    = {1'b1, 52'd0};

	typedef struct packed {
		logic [63:0] dividend_bits;
		logic [63:0] divisor_bits;
	} in_item_t;

	typedef struct packed {
		logic [63:0] remainder_bits;
		logic        invalid;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_NORMX, ST_NORMY, ST_DIV, ST_LAST, ST_RENORM, ST_PACK, ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic norm_x;
		logic norm_y;
		logic div_step;
		logic last_step;
		logic renorm;
		logic pack;
	} cmd_t;

	typedef struct packed {
		logic early;     // result settled at load
		logic x_norm;    // x significand has its leading bit
		logic y_norm;
		logic exp_done;  // exponents equal
		logic zero;      // exact division found
		logic r_norm;    // remainder has its leading bit
	} stat_t;
endpackage
`default_nettype wire

// File: src/dfmod_ctrl.sv
// ----------------------------------------------------------------------------
// dfmod_ctrl: sequencer for the remainder datapath; some items exit early
// Walks normalise, shift-subtract, renormalise and pack, then holds the item.
// ----------------------------------------------------------------------------
`default_nettype none
module dfmod_ctrl import dfmod_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	output cmd_t       cmd,
	input  wire stat_t stat
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_NORMX;
			ST_NORMX:  begin
				if (stat.early)       state_d = ST_OUT;
				else if (stat.x_norm) state_d = ST_NORMY;
			end
			ST_NORMY:  if (stat.y_norm) state_d = ST_DIV;
			ST_DIV:    begin
				// the final compare at equal exponents belongs to ST_LAST
				if (stat.exp_done)  state_d = ST_LAST;
				else if (stat.zero) state_d = ST_OUT;
			end
			ST_LAST:   state_d = stat.zero ? ST_OUT : ST_RENORM;
			ST_RENORM: if (stat.r_norm) state_d = ST_PACK;
			ST_PACK:   state_d = ST_OUT;
			ST_OUT:    if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = (state_q == ST_IDLE);
		out_valid = (state_q == ST_OUT);
		case (state_q)
			ST_IDLE:   cmd.load = in_valid;
			ST_NORMX:  cmd.norm_x = !stat.early;
			ST_NORMY:  cmd.norm_y = 1'b1;
			ST_DIV:    cmd.div_step = !stat.exp_done;
			ST_LAST:   cmd.last_step = 1'b1;
			ST_RENORM: cmd.renorm = 1'b1;
			ST_PACK:   cmd.pack = 1'b1;
			default:   ;
		endcase
	end
endmodule
`default_nettype wire

// File: src/dfmod_dp.sv
// ----------------------------------------------------------------------------
// dfmod_dp: significand and exponent datapath
// Load, then one normalise shift, compare-subtract-shift step, renormalise shift or pack per cycle as commanded.
// ----------------------------------------------------------------------------
`default_nettype none
module dfmod_dp import dfmod_pkg::*; (
	input  wire logic     clk,
	input  wire in_item_t in_item,
	input  wire cmd_t     cmd,
	output stat_t         stat,
	output out_item_t     out_item
);
	logic [53:0] mx_q;
	logic [52:0] my_q;
	logic signed [12:0] ex_q, ey_q;
	logic        sign_q, early_q;
	out_item_t   res_q;

	logic [62:0] ax, ay;
	logic [53:0] diff;
	logic        ge;
	logic [12:0] sh;
	logic [52:0] shifted;

	assign ax   = in_item.dividend_bits[62:0];
	assign ay   = in_item.divisor_bits[62:0];
	assign ge   = mx_q >= {1'b0, my_q};
	assign diff = mx_q - {1'b0, my_q};
	assign sh   = 13'sd1 - ex_q;
	assign shifted = (sh > 13'sd53) ? 53'd0 : mx_q[52:0] >> sh[5:0];

	always_comb begin
		stat          = '0;
		stat.early    = early_q;
		stat.x_norm   = mx_q[52];
		stat.y_norm   = my_q[52];
		stat.exp_done = (ex_q == ey_q);
		stat.zero     = ge && (diff == 54'd0);
		stat.r_norm   = mx_q[52];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sign_q  <= in_item.dividend_bits[63];
			mx_q    <= {2'b0, ax[51:0]} | ((ax[62:52] != 0) ? {1'b0, HIDDEN} : 54'd0);
			my_q    <= {1'b0, ay[51:0]} | ((ay[62:52] != 0) ? HIDDEN : 53'd0);
			ex_q    <= (ax[62:52] == 0) ? 13'sd1 : $signed({2'b0, ax[62:52]});
			ey_q    <= (ay[62:52] == 0) ? 13'sd1 : $signed({2'b0, ay[62:52]});
			if (ay == 63'd0 || ax >= INF_MAG || ay > INF_MAG) begin
				early_q <= 1'b1;
				res_q.remainder_bits <= QNAN_BITS;
				res_q.invalid <= 1'b1;
			end else if (ax < ay) begin
				early_q <= 1'b1;
				res_q.remainder_bits <= in_item.dividend_bits;
				res_q.invalid <= 1'b0;
			end else if (ax == ay) begin
				early_q <= 1'b1;
				res_q.remainder_bits <= {in_item.dividend_bits[63], 63'd0};
				res_q.invalid <= 1'b0;
			end else begin
				early_q <= 1'b0;
				res_q.invalid <= 1'b0;
			end
		end
		if (cmd.norm_x) begin
			if (!mx_q[52]) begin
				mx_q <= mx_q << 1;
				ex_q <= ex_q - 13'sd1;
			end
		end
		if (cmd.norm_y) begin
			if (!my_q[52]) begin
				my_q <= my_q << 1;
				ey_q <= ey_q - 13'sd1;
			end
		end
		if (cmd.div_step || cmd.last_step) begin
			if (ge && diff == 54'd0) begin
				res_q.remainder_bits <= {sign_q, 63'd0};
			end else begin
				if (cmd.div_step) begin
					mx_q <= (ge ? diff : mx_q) << 1;
					ex_q <= ex_q - 13'sd1;
				end else if (ge) begin
					mx_q <= diff;
				end
			end
		end
		if (cmd.renorm && !mx_q[52]) begin
			mx_q <= mx_q << 1;
			ex_q <= ex_q - 13'sd1;
		end
		if (cmd.pack) begin
			if (ex_q > 13'sd0)
				res_q.remainder_bits <= {sign_q, ex_q[10:0], mx_q[51:0]};
			else
				res_q.remainder_bits <= {sign_q, 10'd0, shifted};
		end
	end

	assign out_item = res_q;
endmodule
`default_nettype wire

// File: src/double_fmod_remainder.sv
// Special cases go from load straight to the output register; others pass normalise,
// shift-subtract, renormalise and pack steps; exact divisions skip the last two.
// Throughput: one item at a time; the next is taken the cycle after the result.
// Result is held in an output register until taken.
// Reset: arst_n asynchronous active low returns the sequencer to idle.
// ----------------------------------------------------------------------------
// double_fmod_remainder: binary64 truncated remainder
// Controller and datapath joined by command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none
module double_fmod_remainder import dfmod_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);
	cmd_t  cmd;
	stat_t stat;

	dfmod_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
	);
	dfmod_dp u_dp (
		.clk, .in_item(in_data), .cmd, .stat, .out_item(out_data)
	);
endmodule
`default_nettype wire

// File: src/dfmod_checker.sv
// ----------------------------------------------------------------------------
// dfmod_checker: port-level checks on the remainder block
// Bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module dfmod_checker import dfmod_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);
	`ASSERT_IMPLIES(a_one_side, clk, arst_n, out_valid, !in_ready, "accepting while busy")
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
	`ASSERT_NEXT(a_no_direct, clk, arst_n, in_valid && in_ready, !out_valid, "result too early")
	`ASSERT_IMPLIES(a_nan, clk, arst_n, out_valid && out_data.invalid, out_data.remainder_bits == QNAN_BITS, "invalid without NaN")
endmodule
bind double_fmod_remainder dfmod_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

// File: tb/sv/tb_double_fmod_remainder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_fmod_remainder: self-checking bench for the binary64 remainder
// Drives operand pairs through the valid/ready handshake under several idling
// phases, predicts each remainder bit for bit and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_double_fmod_remainder;
	import dfmod_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	in_item_t  pending_ops[$];
	out_item_t expected_rems[$];
	int        error_count;
	int        send_idle_pct;
	int        recv_stall_pct;
	int        hold_off_cycles;
	bit        in_taken;

	double_fmod_remainder DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Normalise a finite nonzero magnitude into significand and exponent.
	function automatic void split_mag(input logic [62:0] mag, output logic [63:0] sig,
			output int expo);
		int e;
		logic [63:0] m;
		e = int'(mag[62:52]);
		m = {12'd0, mag[51:0]};
		if (e == 0) begin
			e = 1;
			while (m[52] == 1'b0) begin
				m = m << 1;
				e--;
			end
		end else begin
			m[52] = 1'b1;
		end
		sig = m;
		expo = e;
	endfunction

	function automatic out_item_t fmod_bits(input in_item_t op);
		out_item_t r;
		logic [63:0] sgn, mx, my;
		logic [62:0] ax, ay;
		int ex, ey, sh;
		bit zero_hit;
		sgn = {op.dividend_bits[63], 63'd0};
		ax = op.dividend_bits[62:0];
		ay = op.divisor_bits[62:0];
		r.invalid = 1'b0;
		zero_hit = 1'b0;
		if (ay == 63'd0 || ax >= INF_MAG || ay > INF_MAG) begin
			r.remainder_bits = QNAN_BITS;
			r.invalid = 1'b1;
			return r;
		end
		if (ax < ay) begin
			r.remainder_bits = op.dividend_bits;
			return r;
		end
		if (ax == ay) begin
			r.remainder_bits = sgn;
			return r;
		end
		split_mag(ax, mx, ex);
		split_mag(ay, my, ey);
		for (; ex >= ey && !zero_hit; ex--) begin
			if (mx >= my) begin
				if (mx == my) zero_hit = 1'b1;
				mx = mx - my;
			end
			if (ex == ey) break;
			mx = mx << 1;
		end
		if (zero_hit) begin
			r.remainder_bits = sgn;
			return r;
		end
		while (mx[52] == 1'b0) begin
			mx = mx << 1;
			ex--;
		end
		if (ex > 0) begin
			mx = (mx - {11'd0, HIDDEN}) | (64'(ex) << 52);
		end else begin
			sh = 1 - ex;
			mx = (sh < 64) ? (mx >> sh) : 64'd0;
		end
		r.remainder_bits = mx | sgn;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		error_count++;
	endtask

	// Driver: present the next item at the falling edge, hold until taken, and drive out_ready.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_ops.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= (hold_off_cycles > 0) ? 1'b0 :
				($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Record predictions for accepted items, check accepted results.
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_rems.push_back(fmod_bits(in_data));
			if (out_valid && out_ready) begin
				if (expected_rems.size() == 0) begin
					report_mismatch("unexpected result", out_data.remainder_bits, 64'd0);
				end else begin
					if (out_data.remainder_bits !== expected_rems[0].remainder_bits)
						report_mismatch("remainder_bits", out_data.remainder_bits,
							expected_rems[0].remainder_bits);
					if (out_data.invalid !== expected_rems[0].invalid)
						report_mismatch("invalid", 64'(out_data.invalid),
							64'(expected_rems[0].invalid));
					void'(expected_rems.pop_front());
				end
			end
		end
	end

	// Count down the receiver hold-off.
	always @(posedge clk) begin
		if (arst_n && hold_off_cycles > 0) hold_off_cycles--;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Biased operand: mostly normal numbers, often with nearby exponents, plus edges.
	function automatic logic [63:0] pick_operand(input logic [10:0] near_exp);
		logic [63:0] v;
		int k;
		v = rand64();
		k = $urandom_range(99);
		if (k < 45) v[62:52] = near_exp + 11'($urandom_range(40)) - 11'd20;
		else if (k < 55) v[62:52] = 11'd0;
		else if (k < 60) v[62:0] = {11'h7FF, (($urandom_range(1) != 0) ? v[51:0] : 52'd0)};
		else if (k < 63) v[62:0] = 63'd0;
		else if (k < 68) v[51:0] = {52{$urandom_range(1) == 1}};
		return v;
	endfunction

	task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
		in_item_t op;
		logic [10:0] ne;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n; i++) begin
			// Centre both operands on one shared exponent so that many exponent differences stay small.
			ne = ($urandom_range(19) == 0) ? 11'($urandom_range(2046)) :
				11'($urandom_range(2000) + 20);
			op.dividend_bits = pick_operand(ne);
			op.divisor_bits = pick_operand(ne);
			if ($urandom_range(19) == 0)
				op.divisor_bits = op.dividend_bits ^ {1'($urandom_range(1)), 63'd0};
			pending_ops.push_back(op);
		end
		while (pending_ops.size() > 0 || expected_rems.size() > 0 || in_valid)
			@(posedge clk);
	endtask

	function automatic in_item_t mk(input logic [63:0] x, input logic [63:0] y);
		in_item_t op;
		op.dividend_bits = x;
		op.divisor_bits = y;
		return op;
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		in_taken = 1'b0;
		repeat (2) @(posedge clk);
		arst_n = 1'b1;

		pending_ops.push_back(mk(64'h4014_0000_0000_0000, 64'h0000_0000_0000_0000));
		pending_ops.push_back(mk(64'hC014_0000_0000_0000, 64'h8000_0000_0000_0000));
		pending_ops.push_back(mk(64'h7FF0_0000_0000_0000, 64'h4000_0000_0000_0000));
		pending_ops.push_back(mk(64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000));
		pending_ops.push_back(mk(64'h7FF8_0000_0000_0001, 64'h4000_0000_0000_0000));
		pending_ops.push_back(mk(64'h4000_0000_0000_0000, 64'hFFF0_0000_0000_0001));
		pending_ops.push_back(mk(64'h4000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF));
		pending_ops.push_back(mk(64'hC000_0000_0000_0000, 64'h7FF0_0000_0000_0000));
		pending_ops.push_back(mk(64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000));
		pending_ops.push_back(mk(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001));
		pending_ops.push_back(mk(64'hC008_0000_0000_0000, 64'h4008_0000_0000_0000));
		pending_ops.push_back(mk(64'h4018_0000_0000_0000, 64'h4000_0000_0000_0000));
		pending_ops.push_back(mk(64'hC01C_0000_0000_0000, 64'h4000_0000_0000_0000));
		pending_ops.push_back(mk(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001));
		pending_ops.push_back(mk(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0003));
		pending_ops.push_back(mk(64'h7FEF_FFFF_FFFF_FFFF, 64'h000F_FFFF_FFFF_FFFF));
		pending_ops.push_back(mk(64'h000F_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0007));
		pending_ops.push_back(mk(64'h0010_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF));
		pending_ops.push_back(mk(64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0000));
		pending_ops.push_back(mk(64'h0020_0000_0000_0001, 64'h001F_FFFF_FFFF_FFFF));
		pending_ops.push_back(mk(64'hFFEF_FFFF_FFFF_FFFF, 64'h7FE0_0000_0000_0001));
		while (pending_ops.size() > 0 || expected_rems.size() > 0 || in_valid)
			@(posedge clk);

		run_phase(70, 0, 0);
		run_phase(50, 74, 0);
		run_phase(50, 0, 74);
		run_phase(40, 7, 7);
		// Long receiver hold-off while items keep coming, so the input backs up.
		hold_off_cycles = 3000;
		run_phase(40, 0, 0);
		run_phase(30, 30, 30);
		repeat (2200) @(posedge clk);
		if (error_count == 0 && expected_rems.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
